[design/brle_pkg.sv]
// brle_pkg: shared types and constants for the byte run-length encoder
// used by brle_ctrl, brle_dpath and byte_run_length_encoder; no dependencies

package brle_pkg;

   // width of packet lengths and run counters
   localparam int CNT_W = 6;
   localparam int BYTE_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 3;

   // open packet kind
   typedef enum logic [1:0] {
      MODE_EMPTY   = 2'd0,
      MODE_LITERAL = 2'd1,
      MODE_REPEAT  = 2'd2
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_rep_hdr;
      logic load_lit_hdr;
      logic load_lit_data;
      logic last_beat;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic has_lit;
      logic has_rep;
      logic rep_first;
      logic lit_done;
      logic nxt_has_lit;
      logic nxt_has_rep;
      logic nxt_rep_first;
   } status_type;

endpackage

[design/byte_run_length_encoder.sv]
// byte_run_length_encoder: packbits-style run-length encoder, top level
// depends on brle_pkg, brle_ctrl and brle_dpath
//
// usage
//   req channel: one raw byte per beat in req_tdata, req_tlast marks the final
//   byte of a stream. rsp channel: packet beats. a repeat packet is a single
//   header beat (length and byte); a literal packet is a header beat with the
//   length followed by that many data beats.
//   rsp_tuser says what a beat is (header, repeat) and flags the last beat
//   caused by one request byte; rsp_tlast marks the last beat of the stream.
//   a packet is cut at MAX_RUN bytes; the open packet is flushed after tlast.
// flow
//   a byte that only extends the open packet leaves the sequencer idle, so runs
//   stream at one byte per cycle. a byte that closes packets keeps req_tready low
//   while the sequencer loads each result beat (a literal of n bytes is n + 1
//   beats) into the output register as it frees, starting from a header state.
// reset and stall
//   synchronous reset empties the encoder and drops any pending beat; the
//   literal buffer is not cleared. while rsp_tready is low the output register
//   holds its beat and the sequencer waits; req_tready is high only between
//   bursts, including while the last beat of the previous burst still waits.

module byte_run_length_encoder #(
   parameter int MAX_RUN = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] data_byte
   input  logic [brle_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,   // stream_end
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: [5:0] packet_length, [13:6] byte_value, [15:14] zero
   output logic [brle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: [0] is_header, [1] is_repeat, [2] burst_last
   output logic [brle_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast,   // stream_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import brle_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic                 is_header;
   logic                 is_repeat;
   logic [CNT_W-1:0]     packet_length;
   logic [BYTE_W-1:0]    byte_value;
   logic                 burst_last;
   logic                 stream_last;

   // sequencer: accepts a byte when idle, then steps through its packet beats
   brle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, plan, literal buffer and output register
   brle_dpath #(
      .MAX_RUN (MAX_RUN)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_byte         (req_tdata[BYTE_W-1:0]),
      .in_end          (req_tlast),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .out_header      (is_header),
      .out_repeat      (is_repeat),
      .out_length      (packet_length),
      .out_byte        (byte_value),
      .out_burst_last  (burst_last),
      .out_stream_last (stream_last)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {{(RSP_DATA_W - CNT_W - BYTE_W){1'b0}}, byte_value, packet_length};
   assign rsp_tuser = {burst_last, is_repeat, is_header};
   assign rsp_tlast = stream_last;

endmodule

[design/brle_ctrl.sv]
// brle_ctrl: sequencer that orders the header and data beats of one input's packets
// depends on brle_pkg

module brle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  brle_pkg::status_type status,
   output brle_pkg::cmd_type    cmd
);
   import brle_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_REP_HDR  = 4'b0010,
      ST_LIT_HDR  = 4'b0100,
      ST_LIT_DATA = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic lit_then_rep;
   logic rep_then_lit;

   assign lit_then_rep = status.has_rep & ~status.rep_first;
   assign rep_then_lit = status.has_lit & status.rep_first;

   always_comb begin
      state_in          = state_ff;
      req_tready        = 1'b0;
      cmd.accept        = 1'b0;
      cmd.load_rep_hdr  = 1'b0;
      cmd.load_lit_hdr  = 1'b0;
      cmd.load_lit_data = 1'b0;
      cmd.last_beat     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               if (status.nxt_has_rep & (status.nxt_rep_first | ~status.nxt_has_lit)) begin
                  state_in = ST_REP_HDR;
               end else if (status.nxt_has_lit) begin
                  state_in = ST_LIT_HDR;
               end
            end
         end
         ST_REP_HDR: begin
            if (status.out_free) begin
               cmd.load_rep_hdr = 1'b1;
               cmd.last_beat    = ~rep_then_lit;
               state_in         = rep_then_lit ? ST_LIT_HDR : ST_IDLE;
            end
         end
         ST_LIT_HDR: begin
            if (status.out_free) begin
               cmd.load_lit_hdr = 1'b1;
               state_in         = ST_LIT_DATA;
            end
         end
         ST_LIT_DATA: begin
            if (status.out_free) begin
               cmd.load_lit_data = 1'b1;
               if (status.lit_done) begin
                  cmd.last_beat = ~lit_then_rep;
                  state_in      = lit_then_rep ? ST_REP_HDR : ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/brle_dpath.sv]
// brle_dpath: encoder state, packet plan, literal buffer memory and output register
// depends on brle_pkg; driven by brle_ctrl

module brle_dpath #(
   parameter int MAX_RUN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  brle_pkg::cmd_type                 cmd,
   output brle_pkg::status_type              status,
   input  logic [brle_pkg::BYTE_W-1:0]       in_byte,
   input  logic                              in_end,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic                              out_header,
   output logic                              out_repeat,
   output logic [brle_pkg::CNT_W-1:0]        out_length,
   output logic [brle_pkg::BYTE_W-1:0]       out_byte,
   output logic                              out_burst_last,
   output logic                              out_stream_last
);
   import brle_pkg::*;

   localparam int AW = $clog2(MAX_RUN);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RUN);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

   // encoder state
   mode_type             mode_ff, mode_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BYTE_W-1:0]    prev_ff, prev_in;

   // packet plan for the item in flight
   logic [CNT_W-1:0]     lit_len_ff, lit_len_in;
   logic [CNT_W-1:0]     rep_len_ff, rep_len_in;
   logic [BYTE_W-1:0]    rep_val_ff;
   logic                 rep_first_ff, rep_first_in;
   logic                 end_ff;

   logic [CNT_W-1:0]     cnt_inc;
   logic                 byte_eq;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   // literal buffer
   logic [BYTE_W-1:0]    store_mem [MAX_RUN];
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     idx_inc;
   logic                 lit_done;

   // output register
   logic                 valid_ff;
   logic                 hdr_ff;
   logic                 rep_ff;
   logic [CNT_W-1:0]     len_ff;
   logic [BYTE_W-1:0]    val_ff;
   logic                 blast_ff;
   logic                 slast_ff;
   logic                 out_free;
   logic                 load;

   assign cnt_inc = cnt_ff + ONE_CNT;
   assign byte_eq = (in_byte == prev_ff);

   // next state and packet plan for the offered byte
   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      lit_len_in   = '0;
      rep_len_in   = '0;
      rep_first_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      case (mode_ff)
         MODE_LITERAL: begin
            if (byte_eq) begin
               // last literal byte moves into a new repeat
               lit_len_in = cnt_ff - ONE_CNT;
               if (MAX_CNT == TWO_CNT) begin
                  rep_len_in = MAX_CNT;
                  mode_in    = MODE_EMPTY;
                  cnt_in     = '0;
               end else begin
                  mode_in = MODE_REPEAT;
                  cnt_in  = TWO_CNT;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[AW-1:0];
               prev_in = in_byte;
               if (cnt_inc >= MAX_CNT) begin
                  lit_len_in = MAX_CNT;
                  mode_in    = MODE_EMPTY;
                  cnt_in     = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         MODE_REPEAT: begin
            if (byte_eq) begin
               if (cnt_inc >= MAX_CNT) begin
                  rep_len_in = MAX_CNT;
                  mode_in    = MODE_EMPTY;
                  cnt_in     = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end else begin
               rep_len_in   = cnt_ff;
               rep_first_in = 1'b1;
               wr_en        = 1'b1;
               prev_in      = in_byte;
               mode_in      = MODE_LITERAL;
               cnt_in       = ONE_CNT;
            end
         end
         default: begin
            wr_en   = 1'b1;
            prev_in = in_byte;
            mode_in = MODE_LITERAL;
            cnt_in  = ONE_CNT;
         end
      endcase
      // end of stream flushes whatever is open
      if (in_end) begin
         if (mode_in == MODE_LITERAL) begin
            lit_len_in = cnt_in;
         end else if (mode_in == MODE_REPEAT) begin
            rep_len_in = cnt_in;
         end
         mode_in = MODE_EMPTY;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMPTY;
         cnt_ff  <= '0;
         prev_ff <= '0;
      end else if (cmd.accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lit_len_ff   <= lit_len_in;
         rep_len_ff   <= rep_len_in;
         rep_val_ff   <= prev_ff;
         rep_first_ff <= rep_first_in;
         end_ff       <= in_end;
      end
   end

   // buffer read runs one beat ahead of the output
   assign idx_inc  = idx_ff + ONE_CNT;
   assign lit_done = (idx_inc == lit_len_ff);
   assign rd_en    = cmd.load_lit_hdr | (cmd.load_lit_data & ~lit_done);
   assign rd_addr  = cmd.load_lit_hdr ? '0 : idx_inc[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept & wr_en) begin
         store_mem[wr_addr] <= in_byte;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_lit_hdr) begin
         idx_ff <= '0;
      end else if (cmd.load_lit_data) begin
         idx_ff <= idx_inc;
      end
   end

   assign out_free = ~valid_ff | rsp_tready;
   assign load     = cmd.load_rep_hdr | cmd.load_lit_hdr | cmd.load_lit_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hdr_ff   <= ~cmd.load_lit_data;
         rep_ff   <= cmd.load_rep_hdr;
         blast_ff <= cmd.last_beat;
         slast_ff <= cmd.last_beat & end_ff;
         if (cmd.load_rep_hdr) begin
            len_ff <= rep_len_ff;
            val_ff <= rep_val_ff;
         end else if (cmd.load_lit_hdr) begin
            len_ff <= lit_len_ff;
            val_ff <= '0;
         end else begin
            len_ff <= '0;
            val_ff <= rd_data_ff;
         end
      end
   end

   assign rsp_tvalid      = valid_ff;
   assign out_header      = hdr_ff;
   assign out_repeat      = rep_ff;
   assign out_length      = len_ff;
   assign out_byte        = val_ff;
   assign out_burst_last  = blast_ff;
   assign out_stream_last = slast_ff;

   assign status.out_free      = out_free;
   assign status.has_lit       = (lit_len_ff != '0);
   assign status.has_rep       = (rep_len_ff != '0);
   assign status.rep_first     = rep_first_ff;
   assign status.lit_done      = lit_done;
   assign status.nxt_has_lit   = (lit_len_in != '0);
   assign status.nxt_has_rep   = (rep_len_in != '0);
   assign status.nxt_rep_first = rep_first_in;

endmodule
